FILE: design/command_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// Command frame receiver assertion macros
// Shared concurrent assertion forms for the receiver's modules.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_RECEIVER_MACROS_SVH
`define COMMAND_FRAME_RECEIVER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("command_frame_receiver: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("command_frame_receiver: assertion failed");

`else

`define CFR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/cfr_pkg.sv
// ----------------------------------------------------------------------------
// Command frame receiver package
// Frame constants, CRC constants, register indexes and shared types.
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam logic [7:0]  START_BYTE = 8'hAA;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    // Configuration register indexes.
    localparam logic CFG_SHUTDOWN_CODE = 1'b0;
    localparam logic CFG_STARTUP_CODE  = 1'b1;

    localparam logic [7:0] SHUTDOWN_CODE_RESET = 8'd1;
    localparam logic [7:0] STARTUP_CODE_RESET  = 8'd2;

    typedef enum logic [1:0] {
        POS_HUNT   = 2'd0,
        POS_CMD    = 2'd1,
        POS_CRC_LO = 2'd2,
        POS_CRC_HI = 2'd3
    } t_frame_pos;

    typedef enum logic [1:0] {
        ACT_DATA     = 2'd0,
        ACT_SHUTDOWN = 2'd1,
        ACT_STARTUP  = 2'd2
    } t_action;

    typedef struct packed {
        logic       valid;
        logic [7:0] command;
        t_action    action;
    } t_frame_result;

endpackage

FILE: design/cfr_crc16.sv
// ----------------------------------------------------------------------------
// CRC-16/MODBUS of one byte
// Eight reflected shift steps from the all-ones initial value, unrolled.
// ----------------------------------------------------------------------------
module cfr_crc16 (
    input  logic [7:0]  i_data,
    output logic [15:0] o_crc
);
    import cfr_pkg::*;

    always_comb begin
        logic [15:0] c;
        c = CRC_INIT ^ {8'd0, i_data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

FILE: design/cfr_parser.sv
// ----------------------------------------------------------------------------
// Command frame parser
// Tracks the byte position in the frame, holds command and CRC low byte,
// checks the CRC on the last byte and decodes the action.
// ----------------------------------------------------------------------------
`include "command_frame_receiver_macros.svh"

module cfr_parser (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_take,
    input  logic [7:0]             i_byte,
    input  logic [7:0]             i_shutdown_code,
    input  logic [7:0]             i_startup_code,
    output cfr_pkg::t_frame_result o_result
);
    import cfr_pkg::*;

    t_frame_pos  r_pos;
    t_frame_pos  n_pos;
    logic [7:0]  r_held_command;
    logic [7:0]  r_held_crc_low;
    logic [15:0] crc_calc;
    logic        crc_good;

    cfr_crc16 u_crc (
        .i_data (r_held_command),
        .o_crc  (crc_calc)
    );

    assign crc_good = (crc_calc == {i_byte, r_held_crc_low});

    // Next frame position.
    always_comb begin
        n_pos = r_pos;
        if (i_take) begin
            case (r_pos)
                POS_HUNT:   n_pos = (i_byte == START_BYTE) ? POS_CMD : POS_HUNT;
                POS_CMD:    n_pos = POS_CRC_LO;
                POS_CRC_LO: n_pos = POS_CRC_HI;
                POS_CRC_HI: n_pos = POS_HUNT;
                default:    n_pos = POS_HUNT;
            endcase
        end
    end

    // Result on the last byte of a frame; shutdown wins over startup.
    always_comb begin
        o_result.valid   = 1'b0;
        o_result.command = r_held_command;
        o_result.action  = ACT_DATA;
        case (r_pos)
            POS_CRC_HI: o_result.valid = i_take && crc_good;
            default:    o_result.valid = 1'b0;
        endcase
        if (r_held_command == i_shutdown_code) begin
            o_result.action = ACT_SHUTDOWN;
        end else if (r_held_command == i_startup_code) begin
            o_result.action = ACT_STARTUP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && r_pos == POS_CMD) begin
            r_held_command <= i_byte;
        end
        if (i_take && r_pos == POS_CRC_LO) begin
            r_held_crc_low <= i_byte;
        end
    end

    `CFR_ASSERT_IMPLIES(a_result_only_at_frame_end, i_clk, i_rst_n,
        o_result.valid, i_take && r_pos == POS_CRC_HI)
    `CFR_ASSERT_NEXT(a_hunt_drops_other_bytes, i_clk, i_rst_n,
        i_take && r_pos == POS_HUNT && i_byte != START_BYTE, r_pos == POS_HUNT)
    `CFR_ASSERT_NEXT(a_frame_end_rehunts, i_clk, i_rst_n,
        i_take && r_pos == POS_CRC_HI, r_pos == POS_HUNT)

endmodule

FILE: design/command_frame_receiver.sv
// ----------------------------------------------------------------------------
// Command frame receiver
// Finds start-byte framed commands in a received byte stream, checks their
// CRC-16/MODBUS and reports each good command with its action code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received byte per item on i_rx_byte, handshaked by
//   i_valid / o_stall. Output channel: one item per good frame on o_command,
//   o_action and o_reply_request, handshaked by o_valid / i_stall.
//   A frame is 0xAA, command, CRC low, CRC high. Bytes outside a frame and
//   frames with a bad CRC give no output item.
//   The result of a frame's last byte reaches the output through the input
//   register, then the result register.
//   Throughput: one byte per cycle while the output is not stalled; it is
//   set by the single input register feeding the result register.
//   Reset (synchronous, active low) returns to hunting for the start byte,
//   empties both registers and restores shutdown code 1 and startup code 2.
//   While i_stall holds a result, a byte in the input register waits and
//   o_stall rises; the result stays on the output unchanged.
//   Configuration writes through i_cfg_wr_en are expected only while idle.
// ----------------------------------------------------------------------------
`include "command_frame_receiver_macros.svh"

module command_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_command,
    output logic [1:0] o_action,
    output logic       o_reply_request
);
    import cfr_pkg::*;

    logic [7:0]    r_shutdown_val;
    logic [7:0]    r_startup_val;
    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_out_valid;
    logic [7:0]    r_out_command;
    t_action       r_out_action;
    logic          out_free;
    logic          take;
    t_frame_result result;

    assign out_free = !r_out_valid || !i_stall;
    assign take     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shutdown_val  <= SHUTDOWN_CODE_RESET;
            r_startup_val   <= STARTUP_CODE_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SHUTDOWN_CODE: r_shutdown_val <= i_cfg_data;
                CFG_STARTUP_CODE:  r_startup_val  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    cfr_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_byte          (r_in_byte),
        .i_shutdown_code (r_shutdown_val),
        .i_startup_code  (r_startup_val),
        .o_result        (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_out_command <= result.command;
            r_out_action  <= result.action;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_command       = r_out_command;
    assign o_action        = r_out_action;
    assign o_reply_request = 1'b1;

    `CFR_ASSERT_IMPLIES(a_stall_only_when_blocked, i_clk, i_rst_n,
        o_stall, r_in_valid && r_out_valid && i_stall)
    `CFR_ASSERT_IMPLIES(a_action_in_range, i_clk, i_rst_n,
        o_valid, o_action == ACT_DATA || o_action == ACT_SHUTDOWN || o_action == ACT_STARTUP)
    `CFR_ASSERT_IMPLIES(a_shutdown_matches_code, i_clk, i_rst_n,
        o_valid && o_action == ACT_SHUTDOWN && !i_cfg_wr_en, o_command == r_shutdown_val)
    `CFR_ASSERT_NEXT(a_result_lands_in_output, i_clk, i_rst_n,
        result.valid, r_out_valid && r_out_command == $past(result.command))

endmodule
